[rtl/core/ffr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types, codes and the byte-wise crc-16 update for the frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

  // input item modes
  localparam logic [1:0] MODE_BYTE     = 2'd0;
  localparam logic [1:0] MODE_LINE_ERR = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  // verdict status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEN  = 3'd1;
  localparam logic [2:0] ST_BAD_FLAG = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_CRC_ERR  = 3'd4;
  localparam logic [2:0] ST_LINE_ERR = 3'd5;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // configuration register indexes
  localparam logic REG_FLAG_BYTE     = 1'b0;
  localparam logic REG_PAYLOAD_LIMIT = 1'b1;

  localparam logic [7:0] FLAG_RESET  = 8'd126;
  localparam logic [7:0] LIMIT_RESET = 8'd255;

  localparam int unsigned MAX_PAYLOAD    = 255;
  localparam int unsigned FRAME_OVERHEAD = 8;
  localparam int unsigned HEADER_BYTES   = 5;

  localparam logic [7:0] MAX_PAYLOAD_B  = 8'(MAX_PAYLOAD);
  localparam logic [9:0] BURST_MIN      = 10'(FRAME_OVERHEAD);
  localparam logic [9:0] BURST_MAX      = 10'(MAX_PAYLOAD + FRAME_OVERHEAD);
  localparam logic [9:0] HDR_PLUS_CRC   = 10'(HEADER_BYTES + 2);
  localparam logic [8:0] POS_SOURCE     = 9'd1;
  localparam logic [8:0] POS_DEST       = 9'd2;
  localparam logic [8:0] POS_COMMAND    = 9'd3;
  localparam logic [8:0] POS_LENGTH     = 9'd4;
  localparam logic [8:0] POS_BODY       = 9'(HEADER_BYTES);
  localparam logic [8:0] COUNT_MAX      = 9'h1FF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // one queued item after classification
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic       last;
    logic       is_flag;
  } ffr_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  source_addr;
    logic [7:0]  dest_addr;
    logic [7:0]  command_code;
    logic [7:0]  payload_length;
    logic [2:0]  status;
    logic [31:0] crc_error_total;
    logic [31:0] line_error_total;
  } ffr_result_t;

  // crc-16/modbus, reflected, one byte
  function automatic logic [15:0] crc16_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

[rtl/core/flagged_frame_receiver_crc16_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flagged_frame_receiver_crc16_top
// Flag-delimited frame receiver with crc-16/modbus check and error counters.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tdata rx_byte, tuser mode, tlast burst_end
//   out_     out  out_tvalid/out_tready tdata result fields, tuser kind
//   cfg_     in   apb, pready always 1 flag_byte @0x0, payload_limit @0x4
//
// one item per cycle sustained while out_tready stays high; items pass through the
// input register, queue and output register. the byte-wise crc update in the back
// stage sets the clock. reset is synchronous active low, no sweep.
// an output stall fills the queue first, then deasserts in_tready.
// ----------------------------------------------------------------------------
module flagged_frame_receiver_crc16_top import ffr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] rx_byte
  input  logic [1:0]    in_tuser,   // [1:0] mode
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] source_addr,
  // [31:24] dest_addr, [39:32] command_code, [47:40] payload_length,
  // [50:48] status, [82:51] crc_error_total, [114:83] line_error_total
  output logic [119:0]  out_tdata,
  output logic          out_tuser,  // [0] kind
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  logic [7:0]  flag_byte_r, flag_byte_nxt;
  logic [7:0]  limit_r, limit_nxt;
  logic        cfg_wr;
  logic        cfg_sel;

  logic        push_valid, push_ready;
  ffr_item_t   push_item;
  logic        pop_valid, pop_ready;
  ffr_item_t   pop_item;
  ffr_result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[2];

  always_comb begin
    flag_byte_nxt = flag_byte_r;
    limit_nxt     = limit_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_FLAG_BYTE:     flag_byte_nxt = cfg_pwdata[7:0];
        REG_PAYLOAD_LIMIT: limit_nxt     = cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FLAG_BYTE:     cfg_prdata = {24'd0, flag_byte_r};
      REG_PAYLOAD_LIMIT: cfg_prdata = {24'd0, limit_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_byte_r <= FLAG_RESET;
      limit_r     <= LIMIT_RESET;
    end else begin
      flag_byte_r <= flag_byte_nxt;
      limit_r     <= limit_nxt;
    end
  end

  ffr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .flag_byte  (flag_byte_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ffr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ffr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .payload_limit (limit_r),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {5'd0, res.line_error_total, res.crc_error_total, res.status,
                      res.payload_length, res.command_code, res.dest_addr,
                      res.source_addr, res.payload_index, res.payload_byte};

endmodule

[rtl/core/ffr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffr_front
// Input stage: takes items, drops the unused mode, tags delimiter bytes.
// ----------------------------------------------------------------------------
module ffr_front import ffr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic [7:0]  flag_byte,
  output logic        push_valid,
  input  logic        push_ready,
  output ffr_item_t   push_item
);

  logic      valid_r, valid_nxt;
  ffr_item_t item_r, item_nxt;
  logic      keep;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  // mode 3 has no effect at all, so it never enters the queue
  assign keep = (in_mode == MODE_BYTE) || (in_mode == MODE_LINE_ERR) ||
                (in_mode == MODE_CLEAR);

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt        = in_valid && keep;
      item_nxt.mode    = in_mode;
      item_nxt.data    = in_byte;
      item_nxt.last    = in_last;
      item_nxt.is_flag = (in_byte == flag_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

[rtl/core/ffr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffr_queue
// Small fifo of classified items between the front and back stages.
// ----------------------------------------------------------------------------
module ffr_queue import ffr_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  ffr_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output ffr_item_t pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ffr_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/ffr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffr_back
// Frame engine: header capture, crc, payload forwarding, verdicts, counters.
// ----------------------------------------------------------------------------
module ffr_back import ffr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  ffr_item_t   pop_item,
  input  logic [7:0]  payload_limit,
  output logic        res_valid,
  input  logic        res_ready,
  output ffr_result_t res
);

  logic [8:0]  byte_count_r, byte_count_nxt;
  logic        first_ok_r, first_ok_nxt;
  logic [7:0]  hdr_src_r, hdr_src_nxt;
  logic [7:0]  hdr_dst_r, hdr_dst_nxt;
  logic [7:0]  hdr_cmd_r, hdr_cmd_nxt;
  logic [7:0]  hdr_len_r, hdr_len_nxt;
  logic [15:0] run_crc_r, run_crc_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [31:0] crc_cnt_r, crc_cnt_nxt;
  logic [31:0] line_cnt_r, line_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  ffr_result_t out_r, out_nxt;

  logic        take;
  logic [8:0]  off;
  logic [8:0]  len9;
  logic [9:0]  count;
  logic        is_payload;
  logic        len_ok;
  logic        emit;
  logic        clear_frame;
  logic [2:0]  st;

  assign take      = pop_valid && (!out_valid_r || res_ready);
  assign pop_ready = !out_valid_r || res_ready;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  assign off   = byte_count_r - POS_BODY;
  assign len9  = {1'b0, hdr_len_r};
  assign count = {1'b0, byte_count_r} + 10'd1;

  always_comb begin
    byte_count_nxt = byte_count_r;
    first_ok_nxt   = first_ok_r;
    hdr_src_nxt    = hdr_src_r;
    hdr_dst_nxt    = hdr_dst_r;
    hdr_cmd_nxt    = hdr_cmd_r;
    hdr_len_nxt    = hdr_len_r;
    run_crc_nxt    = run_crc_r;
    rx_crc_nxt     = rx_crc_r;
    crc_cnt_nxt    = crc_cnt_r;
    line_cnt_nxt   = line_cnt_r;
    is_payload     = 1'b0;
    emit           = 1'b0;
    clear_frame    = 1'b0;
    st             = ST_OK;
    len_ok         = 1'b0;

    case (pop_item.mode)
      MODE_CLEAR: begin
        crc_cnt_nxt  = '0;
        line_cnt_nxt = '0;
      end
      MODE_LINE_ERR: begin
        if (line_cnt_r != '1) begin
          line_cnt_nxt = line_cnt_r + 32'd1;
        end
        emit        = 1'b1;
        st          = ST_LINE_ERR;
        clear_frame = 1'b1;
      end
      MODE_BYTE: begin
        if (byte_count_r == '0) begin
          first_ok_nxt = pop_item.is_flag;
        end else if (byte_count_r < POS_BODY) begin
          case (byte_count_r)
            POS_SOURCE:  hdr_src_nxt = pop_item.data;
            POS_DEST:    hdr_dst_nxt = pop_item.data;
            POS_COMMAND: hdr_cmd_nxt = pop_item.data;
            default:     hdr_len_nxt = pop_item.data;
          endcase
          run_crc_nxt = crc16_feed(run_crc_r, pop_item.data);
        end else if (off < len9) begin
          run_crc_nxt = crc16_feed(run_crc_r, pop_item.data);
          is_payload  = 1'b1;
        end else if (off == len9) begin
          rx_crc_nxt = {rx_crc_r[15:8], pop_item.data};
        end else if (off == len9 + 9'd1) begin
          rx_crc_nxt = {pop_item.data, rx_crc_r[7:0]};
        end
        byte_count_nxt = (byte_count_r == COUNT_MAX) ? COUNT_MAX : count[8:0];
        len_ok = (hdr_len_nxt <= payload_limit) && (hdr_len_nxt <= MAX_PAYLOAD_B);

        if (!pop_item.last) begin
          emit = is_payload && first_ok_nxt && len_ok;
        end else begin
          emit        = 1'b1;
          clear_frame = 1'b1;
          if (count < BURST_MIN || count > BURST_MAX) begin
            st = ST_BAD_LEN;
          end else if (!first_ok_nxt || !pop_item.is_flag) begin
            st = ST_BAD_FLAG;
          end else if (!len_ok) begin
            st = ST_TOO_LONG;
          end else if (count < HDR_PLUS_CRC + {2'b00, hdr_len_nxt}) begin
            st = ST_BAD_LEN;
          end else if (run_crc_nxt != rx_crc_nxt) begin
            st = ST_CRC_ERR;
            if (crc_cnt_r != '1) begin
              crc_cnt_nxt = crc_cnt_r + 32'd1;
            end
          end else begin
            st = ST_OK;
          end
        end
      end
      default: begin
      end
    endcase

    // result fields come from the header as it stands after this item
    out_nxt.kind             = (is_payload && !pop_item.last &&
                                pop_item.mode == MODE_BYTE) ? KIND_PAYLOAD : KIND_VERDICT;
    out_nxt.payload_byte     = (out_nxt.kind == KIND_PAYLOAD) ? pop_item.data : 8'd0;
    out_nxt.payload_index    = (out_nxt.kind == KIND_PAYLOAD) ? off[7:0] : 8'd0;
    out_nxt.source_addr      = hdr_src_nxt;
    out_nxt.dest_addr        = hdr_dst_nxt;
    out_nxt.command_code     = hdr_cmd_nxt;
    out_nxt.payload_length   = hdr_len_nxt;
    out_nxt.status           = st;
    out_nxt.crc_error_total  = crc_cnt_nxt;
    out_nxt.line_error_total = line_cnt_nxt;

    if (clear_frame) begin
      byte_count_nxt = '0;
      first_ok_nxt   = 1'b0;
      hdr_src_nxt    = '0;
      hdr_dst_nxt    = '0;
      hdr_cmd_nxt    = '0;
      hdr_len_nxt    = '0;
      run_crc_nxt    = CRC_INIT;
      rx_crc_nxt     = '0;
    end

    if (take) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && !res_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      first_ok_r   <= 1'b0;
      hdr_src_r    <= '0;
      hdr_dst_r    <= '0;
      hdr_cmd_r    <= '0;
      hdr_len_r    <= '0;
      run_crc_r    <= CRC_INIT;
      rx_crc_r     <= '0;
      crc_cnt_r    <= '0;
      line_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        byte_count_r <= byte_count_nxt;
        first_ok_r   <= first_ok_nxt;
        hdr_src_r    <= hdr_src_nxt;
        hdr_dst_r    <= hdr_dst_nxt;
        hdr_cmd_r    <= hdr_cmd_nxt;
        hdr_len_r    <= hdr_len_nxt;
        run_crc_r    <= run_crc_nxt;
        rx_crc_r     <= rx_crc_nxt;
        crc_cnt_r    <= crc_cnt_nxt;
        line_cnt_r   <= line_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_r <= out_nxt;
    end
  end

endmodule

[tb/flagged_frame_receiver_crc16_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flagged_frame_receiver_crc16_top_test
// Self-checking bench for the flag-delimited frame receiver. Frames are built
// with a correct crc-16/modbus and then optionally damaged (bad crc, bad flags,
// padding, truncation, line errors). Every accepted item is run through a local
// receiver model and each result on the out_ stream is compared field by
// field, under random input gaps and output stalls and several register
// settings written over the cfg_ port.
// ----------------------------------------------------------------------------
module flagged_frame_receiver_crc16_top_test;
  import ffr_pkg::*;

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    FLAW_NONE, FLAW_CRC, FLAW_OPEN_FLAG, FLAW_CLOSE_FLAG, FLAW_CUT, FLAW_PAD, FLAW_LINE_ERR
  } frame_flaw_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [7:0]    in_tdata;   // [7:0] rx_byte
  logic [1:0]    in_tuser;   // [1:0] mode
  logic          in_tlast;
  logic          out_tvalid;
  logic          out_tready;
  // [7:0] payload_byte, [15:8] payload_index, [23:16] source_addr,
  // [31:24] dest_addr, [39:32] command_code, [47:40] payload_length,
  // [50:48] status, [82:51] crc_error_total, [114:83] line_error_total
  logic [119:0]  out_tdata;
  logic          out_tuser;  // [0] kind
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [2:0]    cfg_paddr;
  logic [31:0]   cfg_pwdata;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  flagged_frame_receiver_crc16_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver model state
  logic [7:0]  cfg_flag;
  logic [7:0]  cfg_limit;
  int unsigned fr_count;
  logic        fr_flag_ok;
  logic [7:0]  hdr_src, hdr_dst, hdr_cmd, hdr_len;
  logic [15:0] crc_run, crc_rx;
  logic [31:0] crc_errs, line_errs;

  ffr_result_t expected_results[$];

  bit          in_gaps_on;
  bit          out_stall_on;
  int          n_errors;
  int          n_items;
  int          n_payloads;
  int          n_verdicts;
  int          n_cfg_writes;
  int unsigned quiet_cycles;

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    acc = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) acc = (acc >> 1) ^ CRC_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  task automatic drop_frame();
    fr_count   = 0;
    fr_flag_ok = 1'b0;
    hdr_src    = '0;
    hdr_dst    = '0;
    hdr_cmd    = '0;
    hdr_len    = '0;
    crc_run    = CRC_INIT;
    crc_rx     = '0;
  endtask

  task automatic push_result(input logic kind, input logic [7:0] pb, input logic [7:0] pi,
                             input logic [2:0] st);
    ffr_result_t r;
    r.kind             = kind;
    r.payload_byte     = pb;
    r.payload_index    = pi;
    r.source_addr      = hdr_src;
    r.dest_addr        = hdr_dst;
    r.command_code     = hdr_cmd;
    r.payload_length   = hdr_len;
    r.status           = st;
    r.crc_error_total  = crc_errs;
    r.line_error_total = line_errs;
    expected_results.push_back(r);
  endtask

  task automatic rx_model_step(input logic [1:0] mode, input logic [7:0] b, input logic last);
    int unsigned pos;
    int unsigned cnt;
    int unsigned off;
    logic        payload_hit;
    logic [7:0]  pidx;
    logic [2:0]  st;
    payload_hit = 1'b0;
    pidx = '0;
    case (mode)
      MODE_CLEAR: begin
        crc_errs  = '0;
        line_errs = '0;
      end
      MODE_LINE_ERR: begin
        if (line_errs != '1) line_errs++;
        push_result(KIND_VERDICT, 8'h00, 8'h00, ST_LINE_ERR);
        drop_frame();
      end
      MODE_BYTE: begin
        pos = fr_count;
        if (pos == 0) begin
          fr_flag_ok = (b == cfg_flag);
        end else if (pos < HEADER_BYTES) begin
          if (pos == POS_SOURCE) hdr_src = b;
          else if (pos == POS_DEST) hdr_dst = b;
          else if (pos == POS_COMMAND) hdr_cmd = b;
          else hdr_len = b;
          crc_run = crc_update(crc_run, b);
        end else begin
          off = pos - HEADER_BYTES;
          if (off < hdr_len) begin
            crc_run = crc_update(crc_run, b);
            payload_hit = 1'b1;
            pidx = 8'(off);
          end else if (off == hdr_len) begin
            crc_rx[7:0] = b;
          end else if (off == hdr_len + 1) begin
            crc_rx[15:8] = b;
          end
        end
        cnt = pos + 1;
        fr_count = (cnt > COUNT_MAX) ? COUNT_MAX : cnt;
        if (!last) begin
          if (payload_hit && fr_flag_ok && hdr_len <= cfg_limit)
            push_result(KIND_PAYLOAD, b, pidx, ST_OK);
        end else begin
          if (cnt < FRAME_OVERHEAD || cnt > MAX_PAYLOAD + FRAME_OVERHEAD) st = ST_BAD_LEN;
          else if (!fr_flag_ok || b != cfg_flag) st = ST_BAD_FLAG;
          else if (hdr_len > cfg_limit) st = ST_TOO_LONG;
          else if (cnt < HEADER_BYTES + hdr_len + 2) st = ST_BAD_LEN;
          else if (crc_run != crc_rx) begin
            st = ST_CRC_ERR;
            if (crc_errs != '1) crc_errs++;
          end else st = ST_OK;
          push_result(KIND_VERDICT, 8'h00, 8'h00, st);
          drop_frame();
        end
      end
      default: ;  // unused mode, ignored
    endcase
  endtask

  // valid is only lowered ahead of a gap, so back-to-back items keep it high
  task automatic send_item(input logic [1:0] mode, input logic [7:0] b, input logic last);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mode;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    rx_model_step(mode, b, last);
    n_items++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // items without a result may still be in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(idx) << 2;
    cfg_pwdata  <= {24'h000000, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_FLAG_BYTE) cfg_flag = value;
    else cfg_limit = value;
    n_cfg_writes++;
    // read back right away
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {24'h000000, value}) begin
      $error("cfg_prdata: expected %0h, actual %0h", {24'h000000, value}, cfg_prdata);
      n_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] flag, input logic [7:0] limit);
    wait_drained();
    write_reg(REG_FLAG_BYTE, flag);
    write_reg(REG_PAYLOAD_LIMIT, limit);
  endtask

  task automatic build_frame(input logic [7:0] src, input logic [7:0] dst,
                             input logic [7:0] cmd, input byte_q_t payload,
                             output byte_q_t fb);
    logic [15:0] c;
    fb = {};
    c = CRC_INIT;
    fb.push_back(cfg_flag);
    fb.push_back(src);
    fb.push_back(dst);
    fb.push_back(cmd);
    fb.push_back(8'(payload.size()));
    for (int i = 1; i < 5; i++) c = crc_update(c, fb[i]);
    foreach (payload[i]) begin
      fb.push_back(payload[i]);
      c = crc_update(c, payload[i]);
    end
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    fb.push_back(cfg_flag);
  endtask

  task automatic send_burst(input byte_q_t fb, input bit with_end);
    foreach (fb[i]) send_item(MODE_BYTE, fb[i], with_end && (i == fb.size() - 1));
  endtask

  task automatic send_frame(input int len, input frame_flaw_t flaw);
    byte_q_t payload;
    byte_q_t fb;
    int      cut;
    payload = {};
    repeat (len) payload.push_back(8'($urandom_range(0, 255)));
    build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), payload, fb);
    case (flaw)
      FLAW_CRC: fb[fb.size() - 3 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      FLAW_OPEN_FLAG: fb[0] ^= 8'($urandom_range(1, 255));
      FLAW_CLOSE_FLAG: fb[fb.size() - 1] ^= 8'($urandom_range(1, 255));
      FLAW_PAD: begin
        repeat ($urandom_range(1, 3)) fb.insert(fb.size() - 1, 8'($urandom_range(0, 255)));
      end
      FLAW_CUT: begin
        cut = $urandom_range(0, fb.size() - 2);
        fb = fb[0:cut];
      end
      default: ;
    endcase
    if (flaw == FLAW_LINE_ERR) begin
      cut = $urandom_range(0, fb.size() - 2);
      fb = fb[0:cut];
      send_burst(fb, 1'b0);
      send_item(MODE_LINE_ERR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      send_burst(fb, 1'b1);
    end
  endtask

  // mostly well-formed frames of small size, some damaged, some stray items
  task automatic random_traffic(input int count);
    int          start;
    int          len;
    frame_flaw_t flaw;
    start = n_items;
    while (n_items - start < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 55) flaw = FLAW_NONE;
        else flaw = frame_flaw_t'($urandom_range(int'(FLAW_CRC), int'(FLAW_LINE_ERR)));
        send_frame(len, flaw);
      end
    end
  endtask

  task automatic test_directed();
    byte_q_t fb;
    byte_q_t payload;
    payload = {8'hFF};
    build_frame(8'h00, 8'hFF, 8'h80, payload, fb);
    send_burst(fb, 1'b1);
    // zero-length payload with a bad crc low byte
    payload = {};
    build_frame(8'hFF, 8'h00, 8'h01, payload, fb);
    fb[5] ^= 8'h01;
    send_burst(fb, 1'b1);
    // burst far too short
    send_item(MODE_BYTE, FLAG_RESET, 1'b0);
    send_item(MODE_BYTE, 8'h00, 1'b1);
    send_item(MODE_LINE_ERR, 8'hFF, 1'b1);
    send_item(MODE_UNUSED, 8'hA5, 1'b1);
    send_item(MODE_CLEAR, 8'h00, 1'b0);
    send_item(MODE_BYTE, FLAG_RESET, 1'b1);
  endtask

  task automatic test_register_settings();
    logic [7:0] flags[5];
    logic [7:0] limits[5];
    flags  = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), FLAG_RESET, 8'h5A};
    limits = '{8'h00, 8'hFF, 8'($urandom_range(1, 12)), 8'h03, LIMIT_RESET};
    for (int s = 0; s < 5; s++) begin
      configure(flags[s], limits[s]);
      random_traffic(20);
    end
  endtask

  task automatic test_long_bursts();
    byte_q_t fb;
    byte_q_t payload;
    configure(FLAG_RESET, LIMIT_RESET);
    // large payload padded just past the longest legal burst, must give bad length
    payload = {};
    repeat (MAX_PAYLOAD - 3) payload.push_back(8'($urandom_range(0, 255)));
    build_frame(8'h12, 8'h34, 8'h56, payload, fb);
    repeat (4) fb.insert(fb.size() - 1, 8'($urandom_range(0, 255)));
    send_burst(fb, 1'b1);
    send_frame(2, FLAW_NONE);
  endtask

  task automatic test_back_to_back();
    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(4, 255)));
    random_traffic(25);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ffr_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: kind %0b tdata %0h", out_tuser, out_tdata);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.kind == KIND_VERDICT) n_verdicts++;
        else n_payloads++;
        check_field("kind", 32'(exp_r.kind), 32'(out_tuser));
        check_field("payload_byte", 32'(exp_r.payload_byte), 32'(out_tdata[7:0]));
        check_field("payload_index", 32'(exp_r.payload_index), 32'(out_tdata[15:8]));
        check_field("source_addr", 32'(exp_r.source_addr), 32'(out_tdata[23:16]));
        check_field("dest_addr", 32'(exp_r.dest_addr), 32'(out_tdata[31:24]));
        check_field("command_code", 32'(exp_r.command_code), 32'(out_tdata[39:32]));
        check_field("payload_length", 32'(exp_r.payload_length), 32'(out_tdata[47:40]));
        check_field("status", 32'(exp_r.status), 32'(out_tdata[50:48]));
        check_field("crc_error_total", exp_r.crc_error_total, out_tdata[82:51]);
        check_field("line_error_total", exp_r.line_error_total, out_tdata[114:83]);
      end
    end
  end

  // random output stalls
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    quiet_cycles = 0;
    n_errors = 0;
    n_items = 0;
    n_payloads = 0;
    n_verdicts = 0;
    n_cfg_writes = 0;
    in_gaps_on = 1'b1;
    out_stall_on = 1'b1;
    cfg_flag = FLAG_RESET;
    cfg_limit = LIMIT_RESET;
    crc_errs = '0;
    line_errs = '0;
    drop_frame();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= MODE_BYTE;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_settings();
    test_long_bursts();
    test_back_to_back();
    wait_drained();

    $display("run covered %0d input items and %0d config writes under gaps and stalls",
             n_items, n_cfg_writes);
    $display("checked %0d payload items and %0d frame verdicts", n_payloads, n_verdicts);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[flagged_frame_receiver_crc16_top.f]
rtl/core/ffr_pkg.sv
rtl/core/ffr_front.sv
rtl/core/ffr_queue.sv
rtl/core/ffr_back.sv
rtl/core/flagged_frame_receiver_crc16_top.sv
tb/flagged_frame_receiver_crc16_top_test.sv
